// File: sv/sfs_pkg.sv
// Shared types, constants and helper functions of the sprite frame sequencer.
package sfs_pkg;

	localparam int MAX_FRAMES = 256;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int COUNT_W    = FRAME_W + 1;
	localparam int TICK_W     = 8;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_START   = 2'd1,
		CMD_ADVANCE = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_FRAME_COUNT = 1'b0,
		REG_STRIP_DELAY = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [TICK_W-1:0]  countdown;
		logic               looping;
		logic               reset_on_finish;
		logic               done;
	} seq_state_t;

	// Clamp the frame count register to 1..MAX_FRAMES.
	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] fc);
		logic [COUNT_W-1:0] n;
		begin
			n = fc;
			if (fc == '0) begin
				n = COUNT_W'(1);
			end else if (fc > COUNT_W'(MAX_FRAMES)) begin
				n = COUNT_W'(MAX_FRAMES);
			end
			return n;
		end
	endfunction

	// Frame a start command begins at.
	function automatic logic [FRAME_W-1:0] start_frame(input logic [COUNT_W-1:0] n,
			input logic at_last, input logic [FRAME_W-1:0] fidx);
		logic [COUNT_W-1:0] last;
		logic [FRAME_W-1:0] f;
		begin
			last = n - COUNT_W'(1);
			f = fidx;
			if (at_last || ({1'b0, fidx} >= n)) begin
				f = last[FRAME_W-1:0];
			end
			return f;
		end
	endfunction

	// Frame that follows f: the next one, or frame 0 past the end.
	function automatic logic [FRAME_W-1:0] next_frame(input logic [COUNT_W-1:0] n,
			input logic [FRAME_W-1:0] f);
		logic [COUNT_W-1:0] inc;
		begin
			inc = {1'b0, f} + COUNT_W'(1);
			return (inc < n) ? inc[FRAME_W-1:0] : '0;
		end
	endfunction

	// Strip delay plus frame delay, saturating.
	function automatic logic [TICK_W-1:0] reload_sum(input logic [TICK_W-1:0] a,
			input logic [TICK_W-1:0] b);
		logic [TICK_W:0] sum;
		begin
			sum = {1'b0, a} + {1'b0, b};
			return sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
		end
	endfunction

endpackage

// File: sv/sfs_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module sfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: command stage, table RAM and result register.
//
// Animation frame sequencer for one strip. Each input transaction carries one command
// (s_tuser: load a frame's hold delay, start the strip, or advance it by a number of
// ticks) and produces exactly one result transaction with the active flag, the frame
// now shown, the done flag and the ticks left on that frame. The block takes one
// command per clock while s_tready is high. The per-frame delay table (a 256 x 8 RAM
// with registered read) is read at the edge that accepts a command; the command then
// waits in stage 1 until the result register is empty or being taken, and is applied
// to the sequencer state at the same edge that loads the result register.
// The table read address for a command is formed from the state as the previous
// command leaves it, so commands may follow each other in consecutive cycles. A result
// register on the output lets one more command enter while a finished result still
// waits; with both full, s_tready drops until m_tready returns. The delay
// table has no reset and needs no clearing pass; the frame whose delay is used must
// have been loaded first. Configuration (frame_count, strip_delay) is written through
// cfg_wen / cfg_index / cfg_data and must only change while no command is in flight.
module sprite_frame_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// Command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] frame_index, [15:8] delay_value, [16] start_at_last, [17] loop_mode,
	// [18] reset_when_done, [19] hold_first, [27:20] advance_steps, [31:28] zero
	input  logic [31:0] s_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_tuser,
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] active, [8:1] current_frame, [9] finished, [17:10] ticks_left, [23:18] zero
	output logic [23:0] m_tdata,
	// Configuration writes
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int FW = sfs_pkg::FRAME_W;
	localparam int CW = sfs_pkg::COUNT_W;
	localparam int TW = sfs_pkg::TICK_W;

	// Configuration registers
	logic [CW-1:0] frame_count_q;
	logic [TW-1:0] strip_delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= CW'(1);
			strip_delay_q <= '0;
		end else if (cfg_wen) begin
			case (sfs_pkg::reg_idx_t'(cfg_index))
				sfs_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_data[CW-1:0];
				sfs_pkg::REG_STRIP_DELAY: strip_delay_q <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] n_eff;
	assign n_eff = sfs_pkg::eff_count(frame_count_q);

	// Unpack the command fields
	sfs_pkg::cmd_t in_cmd;
	logic [FW-1:0] in_fidx;
	logic [TW-1:0] in_dval;
	logic          in_at_last, in_loop, in_rst, in_hold;
	logic [TW-1:0] in_steps;

	assign in_cmd     = sfs_pkg::cmd_t'(s_tuser);
	assign in_fidx    = s_tdata[7:0];
	assign in_dval    = s_tdata[15:8];
	assign in_at_last = s_tdata[16];
	assign in_loop    = s_tdata[17];
	assign in_rst     = s_tdata[18];
	assign in_hold    = s_tdata[19];
	assign in_steps   = s_tdata[27:20];

	// Stage 1: command register, aligned with the table read data
	logic          vld_s1;
	sfs_pkg::cmd_t cmd_s1;
	logic [FW-1:0] fidx_s1;
	logic          at_last_s1, loop_s1, rst_s1, hold_s1;
	logic [TW-1:0] steps_s1;

	logic out_vld_q;
	logic s1_move;
	logic in_accept;

	// Stage 1 drains into the result register when it is empty or being taken
	assign s1_move   = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !vld_s1 || s1_move;
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1     <= in_cmd;
			fidx_s1    <= in_fidx;
			at_last_s1 <= in_at_last;
			loop_s1    <= in_loop;
			rst_s1     <= in_rst;
			hold_s1    <= in_hold;
			steps_s1   <= in_steps;
		end
	end

	// Sequencer state
	sfs_pkg::seq_state_t st_q, st_nxt, st_base;
	logic                act_nxt;
	logic [TW-1:0]       rd_delay;
	logic [TW-1:0]       reload;
	logic [FW-1:0]       f_start;

	assign reload  = sfs_pkg::reload_sum(strip_delay_q, rd_delay);
	assign f_start = sfs_pkg::start_frame(n_eff, at_last_s1, fidx_s1);

	// Apply the command in stage 1 to the state
	always_comb begin
		st_nxt  = st_q;
		act_nxt = !st_q.done;
		case (cmd_s1)
			sfs_pkg::CMD_LOAD: ;
			sfs_pkg::CMD_START: begin
				st_nxt.frame           = f_start;
				st_nxt.looping         = loop_s1 && (n_eff != CW'(1));
				st_nxt.reset_on_finish = rst_s1;
				st_nxt.done            = 1'b0;
				st_nxt.countdown       = (hold_s1 && reload != sfs_pkg::TICK_MAX) ?
					reload + TW'(1) : reload;
				act_nxt                = 1'b1;
			end
			sfs_pkg::CMD_ADVANCE: begin
				if (st_q.done) begin
					act_nxt = 1'b0;
				end else if (st_q.countdown >= steps_s1) begin
					st_nxt.countdown = st_q.countdown - steps_s1;
					act_nxt          = 1'b1;
				end else if (({1'b0, st_q.frame} + CW'(1)) < n_eff) begin
					st_nxt.frame     = st_q.frame + FW'(1);
					st_nxt.countdown = reload;
					act_nxt          = 1'b1;
				end else if (st_q.looping) begin
					st_nxt.frame     = '0;
					st_nxt.countdown = reload;
					act_nxt          = 1'b1;
				end else begin
					// Last frame ran out: finish, optionally rewind to frame 0
					st_nxt.done = 1'b1;
					if (st_q.reset_on_finish) begin
						st_nxt.frame     = '0;
						st_nxt.countdown = sfs_pkg::TICK_MAX;
						act_nxt          = 1'b1;
					end else begin
						act_nxt = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (s1_move) begin
			st_q <= st_nxt;
		end
	end

	// Table access at acceptance. The read address uses the state as the command
	// now leaving stage 1 will leave it, so back-to-back advances see the right frame.
	logic          ram_we, ram_re;
	logic [FW-1:0] ram_raddr;

	assign st_base   = s1_move ? st_nxt : st_q;
	assign ram_we    = in_accept && (in_cmd == sfs_pkg::CMD_LOAD);
	assign ram_re    = in_accept && (in_cmd != sfs_pkg::CMD_LOAD);
	assign ram_raddr = (in_cmd == sfs_pkg::CMD_START) ?
		sfs_pkg::start_frame(n_eff, in_at_last, in_fidx) :
		sfs_pkg::next_frame(n_eff, st_base.frame);

	sfs_ram #(
		.WIDTH (TW),
		.DEPTH (sfs_pkg::MAX_FRAMES)
	) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_fidx),
		.wdata (in_dval),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_delay)
	);

	// Result register: hold until the transaction completes
	logic [23:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q <= {6'd0, st_nxt.countdown, st_nxt.done, st_nxt.frame, act_nxt};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Stage 1 never blocks new commands while it is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("command stage empty but not ready");

	// State only changes when a command retires from stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_move |=> $stable(st_q))
		else $error("sequencer state changed without a command");

	// Finished yet active only after a rewind-on-finish, which shows frame 0 at full count
	a_rewind_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0] && m_tdata[9]) |->
			(m_tdata[8:1] == '0 && m_tdata[17:10] == sfs_pkg::TICK_MAX))
		else $error("finished and active without rewind to frame 0");

	// A table write and a table read never come from the same transaction
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("delay table written and read together");

endmodule
